// File: hw/rtl/nfb_pkg.sv
// Shared constants and types for the neighbour failure blacklist.
`default_nettype none

package nfb_pkg;

  // Table geometry
  localparam int unsigned SLOTS = 4;
  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int unsigned AddrW  = 16;
  localparam int unsigned TickW  = 16;
  localparam int unsigned CountW = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTimeout   = 1'b0,
    CfgThreshold = 1'b1
  } cfg_idx_e;

  localparam logic [TickW-1:0]  TimeoutReset   = 16'd1280;
  localparam logic [CountW-1:0] ThresholdReset = 8'd3;
  localparam logic [CountW-1:0] CountMax       = 8'd255;

  // Report kinds
  localparam logic KindFail    = 1'b0;
  localparam logic KindSuccess = 1'b1;

  // One stored entry: failure count and time of the last failure
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [TickW-1:0]  stamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

`default_nettype wire

// File: hw/rtl/neighbour_failure_blacklist.sv
// Neighbour failure blacklist: per-neighbour transmit failure tracking table.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ----------------------------------
//  report    in         in_valid_i / in_stall_o   kind_i, neighbour_addr_i, now_ticks_i
//  result    out        out_valid_o / out_stall_i declare_dead_o, table_full_o
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// For each request, the accept edge does the address match and issues the
// count/time RAM read; the update and write-back follow when the update stage is done.
// The single RAM read port and the entry read-modify-write keep one request in flight.
// A finished result sits in the output register; the next request is taken
// while it waits. Stalled output holds the update stage until the register frees.
// Reset clears all slot valid bits and loads the register defaults; no clear pass.
`default_nettype none

module neighbour_failure_blacklist (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // report channel
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [nfb_pkg::AddrW-1:0]     neighbour_addr_i,
  input  wire logic [nfb_pkg::TickW-1:0]     now_ticks_i,
  // result channel
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          declare_dead_o,
  output      logic                          table_full_o,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [nfb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [nfb_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned SLOTS  = nfb_pkg::SLOTS;
  localparam int unsigned SlotW  = nfb_pkg::SlotW;
  localparam int unsigned AddrW  = nfb_pkg::AddrW;
  localparam int unsigned TickW  = nfb_pkg::TickW;
  localparam int unsigned CountW = nfb_pkg::CountW;

  // Configuration registers
  logic [TickW-1:0]  timeout_q;
  logic [CountW-1:0] thresh_q;

  // Tag store: valid bits and addresses, matched in parallel
  logic [SLOTS-1:0] valid_q;
  logic [AddrW-1:0] tag_q [SLOTS];

  // Request in flight
  logic             busy_q;
  logic             kind_q;
  logic             hit_q;
  logic             free_ok_q;
  logic [SlotW-1:0] idx_q;
  logic [AddrW-1:0] addr_q;
  logic [TickW-1:0] now_q;

  // Output register
  logic out_valid_q;
  logic dead_q;
  logic full_q;

  logic             accept;
  logic             done;
  logic [SLOTS-1:0] match;
  logic             hit;
  logic             free_ok;
  logic [SlotW-1:0] hit_idx;
  logic [SlotW-1:0] free_idx;

  nfb_pkg::entry_t  rd_entry;
  nfb_pkg::entry_t  wr_entry;
  logic             ram_we;
  logic [TickW-1:0] age;
  logic [CountW-1:0] base_cnt;
  logic [CountW-1:0] new_cnt;
  logic             dead;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = busy_q;
  assign done       = busy_q && (!out_valid_q || !out_stall_i);

  // Parallel address match and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == neighbour_addr_i);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SlotW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
  end

  assign hit     = |match;
  assign free_ok = !(&valid_q);

  // Count/time store
  nfb_ram #(
    .Width (nfb_pkg::EntryW),
    .Depth (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_entry),
    .re_i    (accept),
    .raddr_i (hit_idx),
    .rdata_o (rd_entry)
  );

  // Update: timeout restart, saturating increment, threshold check
  always_comb begin
    age      = now_q - rd_entry.stamp;
    base_cnt = (age > timeout_q) ? '0 : rd_entry.count;
    new_cnt  = (base_cnt == nfb_pkg::CountMax) ? base_cnt : base_cnt + CountW'(1);
    dead     = new_cnt > thresh_q;
    wr_entry.stamp = now_q;
    wr_entry.count = hit_q ? new_cnt : CountW'(1);
    ram_we   = done && (kind_q == nfb_pkg::KindFail) && (hit_q || free_ok_q);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= nfb_pkg::TimeoutReset;
      thresh_q  <= nfb_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      unique case (nfb_pkg::cfg_idx_e'(cfg_idx_i))
        nfb_pkg::CfgTimeout:   timeout_q <= cfg_data_i[TickW-1:0];
        nfb_pkg::CfgThreshold: thresh_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Control state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end

      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (done) begin
        if (kind_q == nfb_pkg::KindSuccess) begin
          if (hit_q) begin
            valid_q[idx_q] <= 1'b0;
          end
        end else if (hit_q) begin
          if (dead) begin
            valid_q[idx_q] <= 1'b0;
          end
        end else if (free_ok_q) begin
          valid_q[idx_q] <= 1'b1;
        end
      end
    end
  end

  // Request capture, tag writes and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= kind_i;
      hit_q     <= hit;
      free_ok_q <= free_ok;
      idx_q     <= hit ? hit_idx : free_idx;
      addr_q    <= neighbour_addr_i;
      now_q     <= now_ticks_i;
    end
    if (done && (kind_q == nfb_pkg::KindFail) && !hit_q && free_ok_q) begin
      tag_q[idx_q] <= addr_q;
    end
    if (done) begin
      dead_q <= (kind_q == nfb_pkg::KindFail) && hit_q && dead;
      full_q <= (kind_q == nfb_pkg::KindFail) && !hit_q && !free_ok_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign declare_dead_o = dead_q;
  assign table_full_o   = full_q;

  // A result never reports both a dead neighbour and a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(declare_dead_o && table_full_o))
    else $error("dead and full reported together");

  // Full table is reported only when every slot was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && (kind_q == nfb_pkg::KindFail) && !hit_q && !free_ok_q) |-> (&valid_q))
    else $error("table full reported with a free slot");

  // A dead neighbour's slot is freed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && (kind_q == nfb_pkg::KindFail) && hit_q && dead) |=> !valid_q[$past(idx_q)])
    else $error("dead neighbour slot still valid");

  // An accepted request is held in flight by the update stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted request not in flight");

  // A finished request always leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q)
    else $error("finished request produced no result");

endmodule

`default_nettype wire

// File: hw/rtl/nfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: test/neighbour_failure_blacklist_tb.sv
// Self-checking testbench for the neighbour failure blacklist table.
`default_nettype none

module neighbour_failure_blacklist_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfb_pkg::*;

  typedef struct {
    logic             kind;
    logic [AddrW-1:0] addr;
    logic [TickW-1:0] now;
  } report_t;

  typedef struct {
    logic dead;
    logic full;
  } verdict_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, known from time zero
  logic                in_valid_i       = 1'b0;
  logic                kind_i           = KindFail;
  logic [AddrW-1:0]    neighbour_addr_i = '0;
  logic [TickW-1:0]    now_ticks_i      = '0;
  logic                out_stall_i      = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i        = CfgTimeout;
  logic [CfgDataW-1:0] cfg_data_i       = '0;

  // block outputs
  logic in_stall_o;
  logic out_valid_o;
  logic declare_dead_o;
  logic table_full_o;

  // request queue, expected verdicts, error count
  report_t     pending_reports[$];
  verdict_t    expected_verdicts[$];
  int unsigned fault_count = 0;
  logic        no_gaps = 1'b0;
  logic [TickW-1:0] tick_now = '0;

  // predictor copy of the table and registers
  logic              tbl_valid [SLOTS];
  logic [AddrW-1:0]  tbl_addr  [SLOTS];
  logic [CountW-1:0] tbl_count [SLOTS];
  logic [TickW-1:0]  tbl_stamp [SLOTS];
  logic [TickW-1:0]  mdl_timeout   = TimeoutReset;
  logic [CountW-1:0] mdl_threshold = ThresholdReset;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  neighbour_failure_blacklist u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .neighbour_addr_i (neighbour_addr_i),
    .now_ticks_i      (now_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .declare_dead_o   (declare_dead_o),
    .table_full_o     (table_full_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Apply one report to the predicted table and return its verdict
  function automatic verdict_t judge_report(report_t r);
    verdict_t         v;
    int               hit;
    int               vacant;
    logic [TickW-1:0] age;
    v.dead = 1'b0;
    v.full = 1'b0;
    hit    = -1;
    vacant = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_addr[i] == r.addr && hit < 0) hit = i;
      if (!tbl_valid[i] && vacant < 0) vacant = i;
    end
    if (r.kind == KindSuccess) begin
      if (hit >= 0) tbl_valid[hit] = 1'b0;
    end else if (hit >= 0) begin
      age = r.now - tbl_stamp[hit];
      if (age > mdl_timeout) tbl_count[hit] = '0;
      if (tbl_count[hit] != CountMax) tbl_count[hit] = tbl_count[hit] + 1'b1;
      tbl_stamp[hit] = r.now;
      if (tbl_count[hit] > mdl_threshold) begin
        v.dead = 1'b1;
        tbl_valid[hit] = 1'b0;
      end
    end else if (vacant < 0) begin
      v.full = 1'b1;
    end else begin
      // fresh entry starts at one, no threshold test
      tbl_valid[vacant] = 1'b1;
      tbl_addr[vacant]  = r.addr;
      tbl_count[vacant] = 8'd1;
      tbl_stamp[vacant] = r.now;
    end
    return v;
  endfunction

  // Request driver: predicts on accept, then loads the next request or idles
  always @(posedge clk_i or negedge rst_ni) begin : report_driver
    report_t next_rpt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_verdicts.push_back(judge_report('{kind_i, neighbour_addr_i, now_ticks_i}));
      end
      if (pending_reports.size() != 0 && (no_gaps || $urandom_range(99) >= 9)) begin
        next_rpt = pending_reports.pop_front();
        in_valid_i       <= 1'b1;
        kind_i           <= next_rpt.kind;
        neighbour_addr_i <= next_rpt.addr;
        now_ticks_i      <= next_rpt.now;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor: compare against the oldest verdict, stall at random
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    verdict_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result, expected none, got dead=%0b full=%0b",
                   $time, declare_dead_o, table_full_o);
        end else begin
          want = expected_verdicts.pop_front();
          if (declare_dead_o !== want.dead) begin
            fault_count++;
            $display("%0t: declare_dead expected %0b got %0b",
                     $time, want.dead, declare_dead_o);
          end
          if (table_full_o !== want.full) begin
            fault_count++;
            $display("%0t: table_full expected %0b got %0b",
                     $time, want.full, table_full_o);
          end
        end
      end
      out_stall_i <= !no_gaps && ($urandom_range(99) < 9);
    end
  end

  task automatic queue_report(input logic kind, input logic [AddrW-1:0] addr,
                              input logic [TickW-1:0] now);
    pending_reports.push_back('{kind, addr, now});
  endtask

  // Wait until every request is through and the pipeline is quiet
  task automatic drain();
    while (pending_reports.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CfgTimeout:   mdl_timeout   = val[TickW-1:0];
      CfgThreshold: mdl_threshold = val[CountW-1:0];
      default: ;
    endcase
  endtask

  // Both registers; junk in the unused upper threshold bits checks masking
  task automatic set_limits(input logic [TickW-1:0] timeout, input logic [CountW-1:0] thr);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    write_reg(CfgTimeout, timeout);
    write_reg(CfgThreshold, {junk[CfgDataW-1:CountW], thr});
  endtask

  // Random traffic over a small address pool, with occasional stray addresses
  task automatic queue_traffic(input int n, input int step_max);
    logic [AddrW-1:0] pool [6];
    logic [AddrW-1:0] addr;
    int               roll;
    for (int k = 0; k < 6; k++) pool[k] = AddrW'($urandom);
    for (int j = 0; j < n; j++) begin
      roll = $urandom_range(99);
      if (roll < 10) tick_now = TickW'($urandom);
      else if (roll >= 30) tick_now = tick_now + TickW'($urandom_range(step_max));
      addr = ($urandom_range(99) < 8) ? AddrW'($urandom) : pool[$urandom_range(5)];
      queue_report(($urandom_range(99) < 15) ? KindSuccess : KindFail, addr, tick_now);
    end
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int unsigned t;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: timeout window edges, wrap, table full, success frees
    queue_report(KindSuccess, 16'h0000, 16'd0);
    queue_report(KindFail,    16'h0000, 16'd0);
    queue_report(KindFail,    16'h0000, 16'd1280);
    queue_report(KindFail,    16'h0000, 16'd2561);
    queue_report(KindFail,    16'h0000, 16'd2561);
    queue_report(KindFail,    16'h0000, 16'd2561);
    queue_report(KindFail,    16'h0000, 16'd2561);
    queue_report(KindFail,    16'hFFFF, 16'hFFFF);
    queue_report(KindFail,    16'hFFFF, 16'h0005);
    queue_report(KindFail,    16'h1234, 16'h0010);
    queue_report(KindFail,    16'hABCD, 16'h0020);
    queue_report(KindFail,    16'h5555, 16'h0030);
    queue_report(KindFail,    16'hAAAA, 16'h0040);
    queue_report(KindSuccess, 16'h1234, 16'h0050);
    queue_report(KindFail,    16'hAAAA, 16'h0060);
    queue_report(KindSuccess, 16'hAAAA, 16'h0070);
    queue_report(KindSuccess, 16'hFFFF, 16'h0080);
    queue_report(KindSuccess, 16'hABCD, 16'h0090);
    queue_report(KindSuccess, 16'h5555, 16'h00A0);
    drain();

    // zero threshold and zero timeout: new entry survives, any repeat is fatal
    set_limits(16'd0, 8'd0);
    queue_report(KindFail, 16'h8001, 16'd100);
    queue_report(KindFail, 16'h8001, 16'd100);
    queue_report(KindFail, 16'h8001, 16'd100);
    queue_report(KindFail, 16'h8001, 16'd101);
    drain();

    // saturation: count pins at its maximum and never passes the threshold
    set_limits(16'hFFFF, CountMax);
    for (int k = 0; k < 258; k++) queue_report(KindFail, 16'h7E81, 16'h4321);
    queue_report(KindFail, 16'h7E81, 16'h4320);
    queue_report(KindSuccess, 16'h7E81, 16'h4322);
    drain();

    // random phases over a spread of register settings
    set_limits(TimeoutReset, ThresholdReset);
    queue_traffic(60, 400);
    drain();
    set_limits(16'd0, 8'd0);
    queue_traffic(40, 3);
    drain();
    set_limits(16'hFFFF, 8'd254);
    queue_traffic(40, 2000);
    drain();
    t = $urandom_range(100, 3000);
    set_limits(TickW'(t), CountW'($urandom_range(1, 5)));
    no_gaps = 1'b1;
    queue_traffic(80, t / 4);
    drain();
    no_gaps = 1'b0;
    set_limits(16'd300, 8'd2);
    queue_traffic(50, 150);
    drain();
    set_limits(TickW'($urandom), CountW'($urandom_range(10)));
    queue_traffic(50, 1000);
    drain();

    repeat (10) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard limit on run length
  initial begin : watchdog
    #(2_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
